// ===== rtl/core/framed_csv_angle_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the framed CSV angle parser
// Shared forms for the concurrent checks on the parser's ports.
// ----------------------------------------------------------------------------
`ifndef FRAMED_CSV_ANGLE_PARSER_MACROS_SVH
`define FRAMED_CSV_ANGLE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCAP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

// ===== rtl/core/fcap_pkg.sv =====
// ----------------------------------------------------------------------------
// fcap_pkg
// Constants and types shared by the framed CSV angle parser files.
// ----------------------------------------------------------------------------
package fcap_pkg;

	localparam int DEFAULT_MAX_CHARS   = 31;
	localparam int DEFAULT_FIELD_COUNT = 6;

	localparam int BYTE_W      = 8;
	localparam int ANGLE_W     = 16;
	localparam int ANGLE_COUNT = 6;

	localparam logic [BYTE_W-1:0] START_MARK = 8'h50; // 'P'
	localparam logic [BYTE_W-1:0] END_MARK   = 8'h0A; // newline
	localparam logic [BYTE_W-1:0] SEP_MARK   = 8'h2C; // ','
	localparam logic [BYTE_W-1:0] PLUS_CHAR  = 8'h2B;
	localparam logic [BYTE_W-1:0] MINUS_CHAR = 8'h2D;
	localparam logic [BYTE_W-1:0] SPACE_CHAR = 8'h20;
	localparam logic [BYTE_W-1:0] TAB_CHAR   = 8'h09;
	localparam logic [BYTE_W-1:0] CR_CHAR    = 8'h0D;
	localparam logic [BYTE_W-1:0] ZERO_CHAR  = 8'h30;
	localparam logic [BYTE_W-1:0] NINE_CHAR  = 8'h39;
	localparam logic [BYTE_W-1:0] NUL_CHAR   = 8'h00;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LEAD,
		PH_DIGITS,
		PH_DONE
	} token_phase_t;

endpackage

// ===== rtl/core/fcap_byte_if.sv =====
// ----------------------------------------------------------------------------
// fcap_byte_if
// Valid/ready channel carrying one received serial byte per request.
// ----------------------------------------------------------------------------
interface fcap_byte_if;
	logic                          valid;
	logic                          ready;
	logic [fcap_pkg::BYTE_W-1:0]   rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/fcap_angle_if.sv =====
// ----------------------------------------------------------------------------
// fcap_angle_if
// Valid/ready channel carrying the six parsed angles of one frame.
// ----------------------------------------------------------------------------
interface fcap_angle_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [fcap_pkg::ANGLE_W-1:0]  angle_1;
	logic signed [fcap_pkg::ANGLE_W-1:0]  angle_2;
	logic signed [fcap_pkg::ANGLE_W-1:0]  angle_3;
	logic signed [fcap_pkg::ANGLE_W-1:0]  angle_4;
	logic signed [fcap_pkg::ANGLE_W-1:0]  angle_5;
	logic signed [fcap_pkg::ANGLE_W-1:0]  angle_6;
	logic                                 fields_missing;

	modport source (
		output valid, output angle_1, output angle_2, output angle_3,
		output angle_4, output angle_5, output angle_6, output fields_missing,
		input ready
	);
	modport sink (
		input valid, input angle_1, input angle_2, input angle_3,
		input angle_4, input angle_5, input angle_6, input fields_missing,
		output ready
	);
endinterface

// ===== rtl/core/framed_csv_angle_parser.sv =====
// ----------------------------------------------------------------------------
// framed_csv_angle_parser
// Frames serial text between 'P' and newline and parses comma separated
// integers into six signed 16-bit angles.
// ----------------------------------------------------------------------------
// Usage:
//   rx carries one received byte per request. Bytes outside a frame are
//   dropped until 'P' opens one. Inside a frame, up to MAX_CHARS bytes (or
//   up to a zero byte) form the text; a newline closes the frame and sends
//   one request on angles with the parsed values and fields_missing.
//   Each token is read like atoi: leading whitespace, optional sign, digits;
//   values wrap modulo 2^16. Empty tokens are skipped, missing ones read 0.
// Throughput: one byte per cycle, unless a closing newline waits on an untaken result.
// Pipeline: two register stages, input byte then result; a newline passes
//   through the input register into the result register, which drives angles.
// Reset: arst_n clears the frame state, the token state, the stored values
//   and both valid flags; the block accepts bytes right after release.
// Stall: a result waits in the output register. Bytes keep flowing while it
//   waits; only a closing newline in the input register, with the previous
//   result still untaken, holds rx.ready low until angles.ready frees it.
// ----------------------------------------------------------------------------
module framed_csv_angle_parser #(
	parameter int MAX_CHARS   = fcap_pkg::DEFAULT_MAX_CHARS,
	parameter int FIELD_COUNT = fcap_pkg::DEFAULT_FIELD_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	fcap_byte_if.sink            rx,
	fcap_angle_if.source         angles
);

	localparam int CC_W = $clog2(MAX_CHARS + 1);
	localparam int FI_W = $clog2(FIELD_COUNT + 1);
	localparam int AW   = fcap_pkg::ANGLE_W;
	localparam int BW   = fcap_pkg::BYTE_W;
	localparam int NA   = fcap_pkg::ANGLE_COUNT;

	// Input register stage
	logic                   valid_s1;
	logic [BW-1:0]          byte_s1;

	// Frame and token state
	logic                   in_frame_q,    in_frame_n;
	logic [CC_W-1:0]        char_count_q,  char_count_n;
	logic                   text_ended_q,  text_ended_n;
	logic [FI_W-1:0]        field_index_q, field_index_n;
	fcap_pkg::token_phase_t phase_q,       phase_n;
	logic                   negative_q,    negative_n;
	logic [AW-1:0]          acc_q,         acc_n;
	logic [AW-1:0]          fv_q [FIELD_COUNT];
	logic [AW-1:0]          fv_n [FIELD_COUNT];

	// Result register
	logic                   out_valid_q;
	logic [AW-1:0]          angle_q [NA];
	logic                   missing_q;

	// Result as it would leave the current newline
	logic [AW-1:0]          res_angle [NA];
	logic                   res_missing;

	logic                   is_close;
	logic                   advance;
	logic                   step;
	logic                   out_load;
	logic                   fin_write;
	logic [AW-1:0]          fin_value;
	logic [FI_W-1:0]        idx_after;
	logic [CC_W-1:0]        cc_inc;
	logic                   c_space;
	logic                   c_sign;
	logic                   c_digit;
	logic [AW-1:0]          acc_next_digit;

	// A newline in a frame needs the result register; hold it while that
	// register still carries a result the sink has not taken.
	assign is_close = valid_s1 && in_frame_q && (byte_s1 == fcap_pkg::END_MARK);
	assign advance  = !(is_close && out_valid_q && !angles.ready);
	assign step     = valid_s1 && advance;
	assign out_load = step && is_close;
	assign rx.ready = !valid_s1 || advance;

	// Character classes of the byte under work
	assign c_space = (byte_s1 == fcap_pkg::SPACE_CHAR) ||
		((byte_s1 >= fcap_pkg::TAB_CHAR) && (byte_s1 <= fcap_pkg::CR_CHAR));
	assign c_sign  = (byte_s1 == fcap_pkg::PLUS_CHAR) || (byte_s1 == fcap_pkg::MINUS_CHAR);
	assign c_digit = (byte_s1 >= fcap_pkg::ZERO_CHAR) && (byte_s1 <= fcap_pkg::NINE_CHAR);

	// acc * 10 + digit, wrapping at 16 bits
	assign acc_next_digit = {acc_q[AW-4:0], 3'b000} + {acc_q[AW-2:0], 1'b0}
		+ AW'(byte_s1 - fcap_pkg::ZERO_CHAR);

	// Closing a token: store it if a slot is left
	assign fin_write = (phase_q != fcap_pkg::PH_IDLE) && (field_index_q < FI_W'(FIELD_COUNT));
	assign fin_value = negative_q ? (AW'(0) - acc_q) : acc_q;
	assign idx_after = field_index_q + FI_W'(fin_write);
	assign cc_inc    = char_count_q + CC_W'(1);

	// Output values, with the token that the newline closes folded in
	genvar k;
	generate
		for (k = 0; k < NA; k++) begin : g_res
			if (k < FIELD_COUNT) begin : g_used
				assign res_angle[k] = (fin_write && (field_index_q == FI_W'(k)))
					? fin_value : fv_q[k];
			end else begin : g_unused
				assign res_angle[k] = '0;
			end
		end
	endgenerate
	assign res_missing = idx_after < FI_W'(FIELD_COUNT);

	always_comb begin
		in_frame_n    = in_frame_q;
		char_count_n  = char_count_q;
		text_ended_n  = text_ended_q;
		field_index_n = field_index_q;
		phase_n       = phase_q;
		negative_n    = negative_q;
		acc_n         = acc_q;
		for (int i = 0; i < FIELD_COUNT; i++) begin
			fv_n[i] = fv_q[i];
		end

		if (step) begin
			if (!in_frame_q) begin
				// Open a frame on the start marker, drop anything else
				if (byte_s1 == fcap_pkg::START_MARK) begin
					in_frame_n    = 1'b1;
					char_count_n  = '0;
					text_ended_n  = 1'b0;
					field_index_n = '0;
					phase_n       = fcap_pkg::PH_IDLE;
					negative_n    = 1'b0;
					acc_n         = '0;
					for (int i = 0; i < FIELD_COUNT; i++) begin
						fv_n[i] = '0;
					end
				end
			end else if (byte_s1 == fcap_pkg::END_MARK) begin
				// Close the frame; the result register takes res_*
				in_frame_n    = 1'b0;
				char_count_n  = '0;
				text_ended_n  = 1'b0;
				field_index_n = '0;
				phase_n       = fcap_pkg::PH_IDLE;
				negative_n    = 1'b0;
				acc_n         = '0;
				for (int i = 0; i < FIELD_COUNT; i++) begin
					fv_n[i] = '0;
				end
			end else if (!text_ended_q) begin
				if (byte_s1 == fcap_pkg::NUL_CHAR) begin
					text_ended_n = 1'b1;
				end else begin
					char_count_n = cc_inc;
					if (cc_inc >= CC_W'(MAX_CHARS)) begin
						text_ended_n = 1'b1;
					end
					if (byte_s1 == fcap_pkg::SEP_MARK) begin
						// Separator: store the pending token, skip empty ones
						if (fin_write) begin
							for (int i = 0; i < FIELD_COUNT; i++) begin
								if (field_index_q == FI_W'(i)) begin
									fv_n[i] = fin_value;
								end
							end
						end
						field_index_n = idx_after;
						phase_n       = fcap_pkg::PH_IDLE;
						negative_n    = 1'b0;
						acc_n         = '0;
					end else begin
						unique case (phase_q)
							fcap_pkg::PH_IDLE, fcap_pkg::PH_LEAD: begin
								if (c_space) begin
									phase_n = fcap_pkg::PH_LEAD;
								end else if (c_sign) begin
									negative_n = (byte_s1 == fcap_pkg::MINUS_CHAR);
									phase_n    = fcap_pkg::PH_DIGITS;
								end else if (c_digit) begin
									acc_n   = acc_next_digit;
									phase_n = fcap_pkg::PH_DIGITS;
								end else begin
									phase_n = fcap_pkg::PH_DONE;
								end
							end
							fcap_pkg::PH_DIGITS: begin
								if (c_digit) begin
									acc_n = acc_next_digit;
								end else begin
									phase_n = fcap_pkg::PH_DONE;
								end
							end
							fcap_pkg::PH_DONE: begin
								phase_n = fcap_pkg::PH_DONE;
							end
							default: begin
								phase_n = phase_q;
							end
						endcase
					end
				end
			end
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			char_count_q  <= '0;
			text_ended_q  <= 1'b0;
			field_index_q <= '0;
			phase_q       <= fcap_pkg::PH_IDLE;
			negative_q    <= 1'b0;
			acc_q         <= '0;
			for (int i = 0; i < FIELD_COUNT; i++) begin
				fv_q[i] <= '0;
			end
		end else begin
			in_frame_q    <= in_frame_n;
			char_count_q  <= char_count_n;
			text_ended_q  <= text_ended_n;
			field_index_q <= field_index_n;
			phase_q       <= phase_n;
			negative_q    <= negative_n;
			acc_q         <= acc_n;
			for (int i = 0; i < FIELD_COUNT; i++) begin
				fv_q[i] <= fv_n[i];
			end
		end
	end

	// Result register: load on a closing newline, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (angles.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < NA; i++) begin
				angle_q[i] <= res_angle[i];
			end
			missing_q <= res_missing;
		end
	end

	assign angles.valid          = out_valid_q;
	assign angles.angle_1        = angle_q[0];
	assign angles.angle_2        = angle_q[1];
	assign angles.angle_3        = angle_q[2];
	assign angles.angle_4        = angle_q[3];
	assign angles.angle_5        = angle_q[4];
	assign angles.angle_6        = angle_q[5];
	assign angles.fields_missing = missing_q;

endmodule

// ===== rtl/core/fcap_checker.sv =====
// ----------------------------------------------------------------------------
// fcap_checker
// Port-level checks for the framed CSV angle parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "framed_csv_angle_parser_macros.svh"

module fcap_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                rx_valid,
	input logic                                rx_ready,
	input logic [fcap_pkg::BYTE_W-1:0]         rx_byte,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [fcap_pkg::ANGLE_W-1:0] angle_1,
	input logic signed [fcap_pkg::ANGLE_W-1:0] angle_2,
	input logic signed [fcap_pkg::ANGLE_W-1:0] angle_3,
	input logic signed [fcap_pkg::ANGLE_W-1:0] angle_4,
	input logic signed [fcap_pkg::ANGLE_W-1:0] angle_5,
	input logic signed [fcap_pkg::ANGLE_W-1:0] angle_6,
	input logic                                fields_missing
);

	// Input backpressure only comes from an untaken result
	`FCAP_ASSERT_IMPLY(a_ready_only_on_stall, clk, arst_n, !rx_ready, out_valid && !out_ready)

	// A fresh result follows an accepted newline request
	`FCAP_ASSERT_IMPLY(a_result_after_newline, clk, arst_n, $rose(out_valid), $past(rx_valid && rx_ready, 2) && ($past(rx_byte, 2) == fcap_pkg::END_MARK))

	// A stalled result holds
	`FCAP_ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(angle_1) && $stable(angle_2) && $stable(angle_3) && $stable(angle_4) && $stable(angle_5) && $stable(angle_6) && $stable(fields_missing))

endmodule

bind framed_csv_angle_parser fcap_checker u_fcap_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rx_valid       (rx.valid),
	.rx_ready       (rx.ready),
	.rx_byte        (rx.rx_byte),
	.out_valid      (angles.valid),
	.out_ready      (angles.ready),
	.angle_1        (angles.angle_1),
	.angle_2        (angles.angle_2),
	.angle_3        (angles.angle_3),
	.angle_4        (angles.angle_4),
	.angle_5        (angles.angle_5),
	.angle_6        (angles.angle_6),
	.fields_missing (angles.fields_missing)
);
